FILE: rtl/brl_pkg.sv
// Shared constants and types for the Bresenham line rasterizer.
package brl_pkg;

   // Default coordinate width
   localparam int COORD_BITS_DEF = 12;

   // Request action codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Flags that travel with each result pixel
   typedef struct packed {
      logic pixel_valid;
      logic last_pixel;
   } brl_flags_type;

endpackage

FILE: rtl/brl_in_stage.sv
// Input register stage: captures one request transfer and holds it for the core.
module brl_in_stage
   import brl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_finish_x,
   input  logic signed [COORD_BITS-1:0] req_finish_y,
   input  logic                         out_free,
   output logic                         item_go,
   output logic                         item_action,
   output logic signed [COORD_BITS-1:0] item_start_x,
   output logic signed [COORD_BITS-1:0] item_start_y,
   output logic signed [COORD_BITS-1:0] item_finish_x,
   output logic signed [COORD_BITS-1:0] item_finish_y
);

   logic                         valid_ff;
   logic                         valid_in;
   logic                         load;
   logic                         action_ff;
   logic signed [COORD_BITS-1:0] start_x_ff;
   logic signed [COORD_BITS-1:0] start_y_ff;
   logic signed [COORD_BITS-1:0] finish_x_ff;
   logic signed [COORD_BITS-1:0] finish_y_ff;

   // Hand the held item on when the result register can take it
   assign item_go   = valid_ff && out_free;
   assign req_stall = valid_ff && !out_free;
   assign load      = req_valid && !req_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (item_go) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Hold valid under reset control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on each accepted transfer
   always_ff @(posedge clock) begin
      if (load) begin
         action_ff   <= req_action;
         start_x_ff  <= req_start_x;
         start_y_ff  <= req_start_y;
         finish_x_ff <= req_finish_x;
         finish_y_ff <= req_finish_y;
      end
   end

   assign item_action   = action_ff;
   assign item_start_x  = start_x_ff;
   assign item_start_y  = start_y_ff;
   assign item_finish_x = finish_x_ff;
   assign item_finish_y = finish_y_ff;

endmodule

FILE: rtl/brl_core.sv
// Line state and combinational setup / step logic of the rasterizer.
module brl_core
   import brl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_go,
   input  logic                         item_action,
   input  logic signed [COORD_BITS-1:0] item_start_x,
   input  logic signed [COORD_BITS-1:0] item_start_y,
   input  logic signed [COORD_BITS-1:0] item_finish_x,
   input  logic signed [COORD_BITS-1:0] item_finish_y,
   output logic signed [COORD_BITS-1:0] res_x,
   output logic signed [COORD_BITS-1:0] res_y,
   output brl_flags_type                res_flags
);

   localparam int N  = COORD_BITS;
   localparam int EW = COORD_BITS + 3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DRAW,
      PH_FINAL
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [N-1:0]          cur_x_ff, cur_x_in;
   logic [N-1:0]          cur_y_ff, cur_y_in;
   logic [EW-1:0]         err_ff, err_in;
   logic [N-1:0]          steps_ff, steps_in;
   logic [N-1:0]          major_ff, major_in;
   logic [N-1:0]          minor_ff, minor_in;
   logic [1:0]            x_step_ff, x_step_in;
   logic [1:0]            y_step_ff, y_step_in;
   logic                  swapped_ff, swapped_in;
   logic [N-1:0]          goal_x_ff, goal_x_in;
   logic [N-1:0]          goal_y_ff, goal_y_in;

   // Setup terms for a new line
   logic [N:0]            dx, dy, neg_dx, neg_dy;
   logic [N-1:0]          adx, ady, set_major, set_minor;
   logic                  set_swap;
   logic [1:0]            set_x_step, set_y_step;
   logic [EW-1:0]         set_err;

   // Step terms
   logic                  err_ge;
   logic [EW-1:0]         twice_major, twice_minor, step_err;
   logic [N-1:0]          x_inc, y_inc;

   // Deltas, magnitudes and directions
   assign dx     = {item_finish_x[N-1], item_finish_x} - {item_start_x[N-1], item_start_x};
   assign dy     = {item_finish_y[N-1], item_finish_y} - {item_start_y[N-1], item_start_y};
   assign neg_dx = ~dx + 1'b1;
   assign neg_dy = ~dy + 1'b1;
   assign adx    = dx[N] ? neg_dx[N-1:0] : dx[N-1:0];
   assign ady    = dy[N] ? neg_dy[N-1:0] : dy[N-1:0];

   assign set_x_step = (dx == '0) ? 2'b00 : (dx[N] ? 2'b11 : 2'b01);
   assign set_y_step = (dy == '0) ? 2'b00 : (dy[N] ? 2'b11 : 2'b01);
   assign set_swap   = ady > adx;
   assign set_major  = set_swap ? ady : adx;
   assign set_minor  = set_swap ? adx : ady;
   assign set_err    = {2'b00, set_minor, 1'b0} - {3'b000, set_major};

   // Error update and axis increments for one step
   assign twice_major = {2'b00, major_ff, 1'b0};
   assign twice_minor = {2'b00, minor_ff, 1'b0};
   assign err_ge      = !err_ff[EW-1];
   assign step_err    = err_ff + twice_minor - (err_ge ? twice_major : '0);
   assign x_inc       = {{(N-2){x_step_ff[1]}}, x_step_ff};
   assign y_inc       = {{(N-2){y_step_ff[1]}}, y_step_ff};

   always_comb begin
      phase_in   = phase_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      err_in     = err_ff;
      steps_in   = steps_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      x_step_in  = x_step_ff;
      y_step_in  = y_step_ff;
      swapped_in = swapped_ff;
      goal_x_in  = goal_x_ff;
      goal_y_in  = goal_y_ff;
      res_x      = '0;
      res_y      = '0;
      res_flags  = '{pixel_valid: 1'b0, last_pixel: 1'b0};

      if (item_action == ACT_START) begin
         // Latch the new line and emit its first endpoint
         cur_x_in   = item_start_x;
         cur_y_in   = item_start_y;
         goal_x_in  = item_finish_x;
         goal_y_in  = item_finish_y;
         err_in     = set_err;
         steps_in   = set_major;
         major_in   = set_major;
         minor_in   = set_minor;
         x_step_in  = set_x_step;
         y_step_in  = set_y_step;
         swapped_in = set_swap;
         phase_in   = (set_major == '0) ? PH_FINAL : PH_DRAW;
         res_x      = item_start_x;
         res_y      = item_start_y;
         res_flags  = '{pixel_valid: 1'b1, last_pixel: 1'b0};
      end else begin
         unique case (phase_ff)
            PH_DRAW: begin
               // Advance along the major axis, and the minor one when due
               err_in = step_err;
               if (swapped_ff) begin
                  cur_y_in = cur_y_ff + y_inc;
                  cur_x_in = err_ge ? cur_x_ff + x_inc : cur_x_ff;
               end else begin
                  cur_x_in = cur_x_ff + x_inc;
                  cur_y_in = err_ge ? cur_y_ff + y_inc : cur_y_ff;
               end
               steps_in = steps_ff - 1'b1;
               if (steps_ff == {{(N-1){1'b0}}, 1'b1}) begin
                  phase_in = PH_FINAL;
               end
               res_x     = cur_x_in;
               res_y     = cur_y_in;
               res_flags = '{pixel_valid: 1'b1, last_pixel: 1'b0};
            end
            PH_FINAL: begin
               // Repeat the second endpoint, flagged as last
               phase_in  = PH_IDLE;
               res_x     = goal_x_ff;
               res_y     = goal_y_ff;
               res_flags = '{pixel_valid: 1'b1, last_pixel: 1'b1};
            end
            default: begin
               // Idle: drop the step with an invalid pixel
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Hold line state; advance it on each item handed on
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (item_go) begin
         phase_ff <= phase_in;
      end
      if (item_go) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         err_ff     <= err_in;
         steps_ff   <= steps_in;
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         x_step_ff  <= x_step_in;
         y_step_ff  <= y_step_in;
         swapped_ff <= swapped_in;
         goal_x_ff  <= goal_x_in;
         goal_y_ff  <= goal_y_in;
      end
   end

endmodule

FILE: rtl/brl_out_stage.sv
// Result register stage: holds one pixel until the response transfer completes.
module brl_out_stage
   import brl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_go,
   input  logic signed [COORD_BITS-1:0] res_x,
   input  logic signed [COORD_BITS-1:0] res_y,
   input  brl_flags_type                res_flags,
   output logic                         out_free,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_pixel_valid,
   output logic                         rsp_last_pixel
);

   logic                         valid_ff;
   logic                         valid_in;
   logic signed [COORD_BITS-1:0] x_ff;
   logic signed [COORD_BITS-1:0] y_ff;
   brl_flags_type                flags_ff;

   // Room for a new result when empty or the current one leaves now
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (item_go) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (item_go) begin
         x_ff     <= res_x;
         y_ff     <= res_y;
         flags_ff <= res_flags;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_x     = x_ff;
   assign rsp_pixel_y     = y_ff;
   assign rsp_pixel_valid = flags_ff.pixel_valid;
   assign rsp_last_pixel  = flags_ff.last_pixel;

endmodule

FILE: rtl/bresenham_line_rasterizer_top.sv
// Bresenham line rasterizer: one pixel result for each request transfer.
// Path: input register, then setup/step logic into the result register.
// Throughput: one request per cycle unless rsp_stall holds a result; the
// one-step error update and axis add sit between the two registers, so a
// full line runs at one pixel per clock.
// Reset (synchronous): empties both registers and leaves the drawing idle.
module bresenham_line_rasterizer_top
   import brl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_finish_x,
   input  logic signed [COORD_BITS-1:0] req_finish_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_pixel_valid,
   output logic                         rsp_last_pixel
);

   logic                         out_free;
   logic                         item_go;
   logic                         item_action;
   logic signed [COORD_BITS-1:0] item_start_x;
   logic signed [COORD_BITS-1:0] item_start_y;
   logic signed [COORD_BITS-1:0] item_finish_x;
   logic signed [COORD_BITS-1:0] item_finish_y;
   logic signed [COORD_BITS-1:0] res_x;
   logic signed [COORD_BITS-1:0] res_y;
   brl_flags_type                res_flags;

   brl_in_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_finish_x  (req_finish_x),
      .req_finish_y  (req_finish_y),
      .out_free      (out_free),
      .item_go       (item_go),
      .item_action   (item_action),
      .item_start_x  (item_start_x),
      .item_start_y  (item_start_y),
      .item_finish_x (item_finish_x),
      .item_finish_y (item_finish_y)
   );

   brl_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .item_go       (item_go),
      .item_action   (item_action),
      .item_start_x  (item_start_x),
      .item_start_y  (item_start_y),
      .item_finish_x (item_finish_x),
      .item_finish_y (item_finish_y),
      .res_x         (res_x),
      .res_y         (res_y),
      .res_flags     (res_flags)
   );

   brl_out_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .item_go         (item_go),
      .res_x           (res_x),
      .res_y           (res_y),
      .res_flags       (res_flags),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_last_pixel  (rsp_last_pixel)
   );

`ifndef SYNTHESIS
   // Requests back up only behind a held, stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while result side is free");

   // A last pixel is always a real pixel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_pixel) |-> rsp_pixel_valid)
      else $error("last pixel flagged without a valid pixel");

   // Reset empties the result register
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
